FILE: rtl/assert_macros.svh
// Assertion shorthands, sampled on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mtrnn_pkg.sv
package mtrnn_pkg;

    localparam int HIDDEN_UNITS = 16;
    localparam int INPUT_UNITS  = 2;
    localparam int OUTPUT_UNITS = 2;
    localparam int HID_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

    // weight memory layout
    localparam int HH        = HIDDEN_UNITS * HIDDEN_UNITS;
    localparam int OFF_IF    = 0;
    localparam int OFF_FF    = OFF_IF + INPUT_UNITS * HIDDEN_UNITS;
    localparam int OFF_SF    = OFF_FF + HH;
    localparam int OFF_SS    = OFF_SF + HH;
    localparam int OFF_FS    = OFF_SS + HH;
    localparam int OFF_FO    = OFF_FS + HH;
    localparam int OFF_BF    = OFF_FO + HIDDEN_UNITS * OUTPUT_UNITS;
    localparam int OFF_BS    = OFF_BF + HIDDEN_UNITS;
    localparam int OFF_BO    = OFF_BS + HIDDEN_UNITS;
    localparam int MEM_DEPTH = OFF_BO + OUTPUT_UNITS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // highest MAC term index per accumulation: bias, inputs, two contexts per source
    localparam int TERM_MAX = 2 * HIDDEN_UNITS + 2;
    localparam int TERM_W   = $clog2(TERM_MAX + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FAST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SLOW = 1'd1;
    localparam logic [CFG_DATA_W-1:0] INV_FAST_RESET = 13'd2048;
    localparam logic [CFG_DATA_W-1:0] INV_SLOW_RESET = 13'd819;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [3:0] SEL_IN_FAST   = 4'd0;
    localparam logic [3:0] SEL_FAST_FAST = 4'd1;
    localparam logic [3:0] SEL_SLOW_FAST = 4'd2;
    localparam logic [3:0] SEL_SLOW_SLOW = 4'd3;
    localparam logic [3:0] SEL_FAST_SLOW = 4'd4;
    localparam logic [3:0] SEL_FAST_OUT  = 4'd5;
    localparam logic [3:0] SEL_BIAS_FAST = 4'd6;
    localparam logic [3:0] SEL_BIAS_SLOW = 4'd7;
    localparam logic [3:0] SEL_BIAS_OUT  = 4'd8;

    localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

    // exp(-mag/2048) is built as a product of exp(-2^i/2048) over the set bits of mag
    localparam int E_FRAC   = 40;
    localparam int E_W      = E_FRAC + 1;
    localparam int EXP_BITS = 16;

    typedef logic [E_FRAC-1:0] exp_tbl_t [EXP_BITS];

    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t t;
        for (int i = 0; i < EXP_BITS; i++)
        begin
            t[i] = E_FRAC'(longint'($exp(-(2.0 ** i) / 2048.0) * (2.0 ** E_FRAC)));
        end
        return t;
    endfunction

    localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

FILE: rtl/mtrnn_if.sv
interface mtrnn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         matrix_sel;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] x_first;
    logic signed [15:0] x_second;

    modport source (output valid, kind, matrix_sel, row_index, col_index,
                    weight_value, x_first, x_second, input ready);
    modport sink (input valid, kind, matrix_sel, row_index, col_index,
                  weight_value, x_first, x_second, output ready);
endinterface

interface mtrnn_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] y_first;
    logic signed [13:0] y_second;
    logic               saturated;

    modport source (output valid, y_first, y_second, saturated, input ready);
    modport sink (input valid, y_first, y_second, saturated, output ready);
endinterface

FILE: rtl/mtrnn_forward_step.sv
// Load and clear beats finish in the cycle they are accepted; kind 3 is dropped.
// A step beat runs the MAC work (one term per cycle, then a drain and an
// integrate through S_INT0 and S_INT1 per potential) and 34 tanh evaluations,
// all on the one shared multiplier.
// Busy for the whole step; the result then sits in the output register.
// rst_n clears potentials, contexts and control; weight memory is unset.
module mtrnn_forward_step
    import mtrnn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mtrnn_in_if.sink              item,
    mtrnn_out_if.source           result
);

    localparam int ACC_W  = 40;
    localparam int PROD_W = 63;
    localparam int DIV_W  = 56;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MAC     = 4'd1;
    localparam logic [3:0] S_DRAIN   = 4'd2;
    localparam logic [3:0] S_INT0    = 4'd3;
    localparam logic [3:0] S_INT1    = 4'd4;
    localparam logic [3:0] S_TH_LOAD = 4'd5;
    localparam logic [3:0] S_TH_BIT  = 4'd6;
    localparam logic [3:0] S_TH_MLO  = 4'd7;
    localparam logic [3:0] S_TH_MHI  = 4'd8;
    localparam logic [3:0] S_TH_ACC  = 4'd9;
    localparam logic [3:0] S_DIV     = 4'd10;
    localparam logic [3:0] S_TH_DONE = 4'd11;
    localparam logic [3:0] S_FINISH  = 4'd12;

    localparam logic [2:0] PH_FAST = 3'd0;
    localparam logic [2:0] PH_SLOW = 3'd1;
    localparam logic [2:0] PH_TF   = 3'd2;
    localparam logic [2:0] PH_TS   = 3'd3;
    localparam logic [2:0] PH_OUT  = 3'd4;

    localparam logic signed [ACC_W-1:0]  ACC_HALF  = 2048;
    localparam logic signed [ACC_W-1:0]  ACC_HI    = 32767;
    localparam logic signed [ACC_W-1:0]  ACC_LO    = -32768;
    localparam logic signed [PROD_W-1:0] PROD_HALF = 2048;
    localparam logic signed [20:0]       POT_HI    = 32767;
    localparam logic signed [20:0]       POT_LO    = -32768;
    localparam logic [E_W-1:0]           E_ONE     = {1'b1, {E_FRAC{1'b0}}};

    logic [3:0]        state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [HID_W-1:0]  d_reg, d_next;
    logic [TERM_W-1:0] k_reg, k_next;

    logic [CFG_DATA_W-1:0] inv_fast_reg, inv_slow_reg;
    logic signed [15:0] x0_reg, x1_reg;
    logic signed [15:0] fpot_reg [HIDDEN_UNITS];
    logic signed [15:0] spot_reg [HIDDEN_UNITS];
    logic signed [15:0] fctx_reg [HIDDEN_UNITS];
    logic signed [15:0] sctx_reg [HIDDEN_UNITS];

    logic signed [15:0] mem [MEM_DEPTH];
    logic signed [15:0] rdata_reg;
    logic signed [15:0] a1_reg;
    logic               v1_reg, v2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               flag_reg;

    logic [E_W-1:0]     e_reg;
    logic [E_FRAC-1:0]  lo_reg;
    logic [15:0]        mag_reg;
    logic               neg_reg;
    logic [4:0]         bit_reg;
    logic [DIV_W-1:0]   rem_reg, dsh_reg;
    logic [12:0]        q_reg;
    logic [3:0]         cnt_reg;

    logic signed [13:0] y0_reg;
    logic signed [13:0] y_first_reg, y_second_reg;
    logic               sat_reg, out_valid_reg;

    logic item_acc;
    assign item_acc    = item.valid && item.ready;
    assign item.ready  = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.y_first   = y_first_reg;
    assign result.y_second  = y_second_reg;
    assign result.saturated = sat_reg;

    // load address decode
    logic              load_ok;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] src_a, dst_a;

    always_comb
    begin
        src_a     = ADDR_W'(item.row_index);
        dst_a     = ADDR_W'(item.col_index);
        load_ok   = 1'b0;
        load_addr = '0;
        unique case (item.matrix_sel)
            SEL_IN_FAST:
            begin
                load_ok   = item.row_index < INPUT_UNITS && item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_IF) + src_a * ADDR_W'(HIDDEN_UNITS) + dst_a;
            end
            SEL_FAST_FAST:
            begin
                load_ok   = item.row_index < HIDDEN_UNITS && item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_FF) + src_a * ADDR_W'(HIDDEN_UNITS) + dst_a;
            end
            SEL_SLOW_FAST:
            begin
                load_ok   = item.row_index < HIDDEN_UNITS && item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_SF) + src_a * ADDR_W'(HIDDEN_UNITS) + dst_a;
            end
            SEL_SLOW_SLOW:
            begin
                load_ok   = item.row_index < HIDDEN_UNITS && item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_SS) + src_a * ADDR_W'(HIDDEN_UNITS) + dst_a;
            end
            SEL_FAST_SLOW:
            begin
                load_ok   = item.row_index < HIDDEN_UNITS && item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_FS) + src_a * ADDR_W'(HIDDEN_UNITS) + dst_a;
            end
            SEL_FAST_OUT:
            begin
                load_ok   = item.row_index < HIDDEN_UNITS && item.col_index < OUTPUT_UNITS;
                load_addr = ADDR_W'(OFF_FO) + src_a * ADDR_W'(OUTPUT_UNITS) + dst_a;
            end
            SEL_BIAS_FAST:
            begin
                load_ok   = item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_BF) + dst_a;
            end
            SEL_BIAS_SLOW:
            begin
                load_ok   = item.col_index < HIDDEN_UNITS;
                load_addr = ADDR_W'(OFF_BS) + dst_a;
            end
            SEL_BIAS_OUT:
            begin
                load_ok   = item.col_index < OUTPUT_UNITS;
                load_addr = ADDR_W'(OFF_BO) + dst_a;
            end
            default:
            begin
                load_ok   = 1'b0;
                load_addr = '0;
            end
        endcase
    end

    // MAC term for the current phase, destination d and term k
    logic [TERM_W-1:0]  m_f, m_s;
    logic [HID_W-1:0]   s_f, s_s, s_o;
    logic [ADDR_W-1:0]  d_a;
    logic signed [15:0] term_a;
    logic [ADDR_W-1:0]  term_addr;
    logic [TERM_W-1:0]  term_last;

    always_comb
    begin
        m_f = k_reg - TERM_W'(3);
        m_s = k_reg - TERM_W'(1);
        s_f = m_f[HID_W:1];
        s_s = m_s[HID_W:1];
        s_o = m_s[HID_W-1:0];
        d_a = ADDR_W'(d_reg);
        term_a    = ONE_Q12;
        term_addr = '0;
        term_last = TERM_W'(HIDDEN_UNITS);
        unique case (phase_reg)
            PH_FAST:
            begin
                term_last = TERM_W'(2 * HIDDEN_UNITS + 2);
                if (k_reg == '0)
                begin
                    term_addr = ADDR_W'(OFF_BF) + d_a;
                end
                else if (k_reg == TERM_W'(1))
                begin
                    term_a    = x0_reg;
                    term_addr = ADDR_W'(OFF_IF) + d_a;
                end
                else if (k_reg == TERM_W'(2))
                begin
                    term_a    = x1_reg;
                    term_addr = ADDR_W'(OFF_IF + HIDDEN_UNITS) + d_a;
                end
                else if (!m_f[0])
                begin
                    term_a    = fctx_reg[s_f];
                    term_addr = ADDR_W'(OFF_FF) + ADDR_W'(s_f) * ADDR_W'(HIDDEN_UNITS) + d_a;
                end
                else
                begin
                    term_a    = sctx_reg[s_f];
                    term_addr = ADDR_W'(OFF_SF) + ADDR_W'(s_f) * ADDR_W'(HIDDEN_UNITS) + d_a;
                end
            end
            PH_SLOW:
            begin
                term_last = TERM_W'(2 * HIDDEN_UNITS);
                if (k_reg == '0)
                begin
                    term_addr = ADDR_W'(OFF_BS) + d_a;
                end
                else if (!m_s[0])
                begin
                    term_a    = sctx_reg[s_s];
                    term_addr = ADDR_W'(OFF_SS) + ADDR_W'(s_s) * ADDR_W'(HIDDEN_UNITS) + d_a;
                end
                else
                begin
                    term_a    = fctx_reg[s_s];
                    term_addr = ADDR_W'(OFF_FS) + ADDR_W'(s_s) * ADDR_W'(HIDDEN_UNITS) + d_a;
                end
            end
            default:
            begin
                term_last = TERM_W'(HIDDEN_UNITS);
                if (k_reg == '0)
                begin
                    term_addr = ADDR_W'(OFF_BO) + d_a;
                end
                else
                begin
                    term_a    = fctx_reg[s_o];
                    term_addr = ADDR_W'(OFF_FO) + ADDR_W'(s_o) * ADDR_W'(OUTPUT_UNITS) + d_a;
                end
            end
        endcase
    end

    // rounding, saturation and integration
    logic signed [ACC_W-1:0]  acc_rnd;
    logic                     pre_ovf;
    logic signed [15:0]       pre_sat;
    logic signed [15:0]       pot_cur;
    logic [CFG_DATA_W-1:0]    inv_cur;
    logic signed [16:0]       diff;
    logic signed [PROD_W-1:0] step_full;
    logic signed [19:0]       step;
    logic signed [20:0]       pot_sum;
    logic                     pot_ovf;
    logic signed [15:0]       pot_new;

    always_comb
    begin
        acc_rnd   = (acc_reg + ACC_HALF) >>> 12;
        pre_ovf   = (acc_rnd > ACC_HI) || (acc_rnd < ACC_LO);
        if (acc_rnd > ACC_HI)
            pre_sat = 16'sh7fff;
        else if (acc_rnd < ACC_LO)
            pre_sat = -16'sh8000;
        else
            pre_sat = acc_rnd[15:0];
        pot_cur   = (phase_reg == PH_SLOW) ? spot_reg[d_reg] : fpot_reg[d_reg];
        inv_cur   = (phase_reg == PH_SLOW) ? inv_slow_reg : inv_fast_reg;
        diff      = 17'(pre_sat) - 17'(pot_cur);
        step_full = (prod_reg + PROD_HALF) >>> 12;
        step      = step_full[19:0];
        pot_sum   = 21'(pot_cur) + 21'(step);
        pot_ovf   = (pot_sum > POT_HI) || (pot_sum < POT_LO);
        if (pot_sum > POT_HI)
            pot_new = 16'sh7fff;
        else if (pot_sum < POT_LO)
            pot_new = -16'sh8000;
        else
            pot_new = pot_sum[15:0];
    end

    // tanh front end and divider operands
    logic signed [15:0] th_src;
    logic signed [16:0] th_ext, th_mag;
    logic [DIV_W-1:0]   n_val, dd_val;
    logic signed [13:0] tq;

    always_comb
    begin
        unique case (phase_reg)
            PH_TF:   th_src = fpot_reg[d_reg];
            PH_TS:   th_src = spot_reg[d_reg];
            default: th_src = pre_sat;
        endcase
        th_ext = 17'(th_src);
        th_mag = th_src[15] ? -th_ext : th_ext;
        // q = floor((8192*(1-e) + (1+e)) / (2*(1+e)))
        n_val  = (DIV_W'(E_ONE - e_reg) << 13) + DIV_W'(E_ONE) + DIV_W'(e_reg);
        dd_val = (DIV_W'(E_ONE) + DIV_W'(e_reg)) << 13;
        tq     = neg_reg ? -signed'({1'b0, q_reg}) : signed'({1'b0, q_reg});
    end

    // the shared multiplier
    logic signed [21:0] mul_a;
    logic signed [40:0] mul_b;

    always_comb
    begin
        unique case (state_reg)
            S_INT0:
            begin
                mul_a = signed'({9'b0, inv_cur});
                mul_b = 41'(diff);
            end
            S_TH_MLO:
            begin
                mul_a = signed'({2'b0, e_reg[19:0]});
                mul_b = signed'({1'b0, EXP_TBL[bit_reg[3:0]]});
            end
            S_TH_MHI:
            begin
                mul_a = signed'({1'b0, e_reg[E_W-1:20]});
                mul_b = signed'({1'b0, EXP_TBL[bit_reg[3:0]]});
            end
            default:
            begin
                mul_a = 22'(a1_reg);
                mul_b = 41'(rdata_reg);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && item.kind == KIND_STEP)
                begin
                    state_next = S_MAC;
                    phase_next = PH_FAST;
                    d_next     = '0;
                    k_next     = '0;
                end
            end
            S_MAC:
            begin
                if (k_reg == term_last)
                    state_next = S_DRAIN;
                else
                    k_next = k_reg + TERM_W'(1);
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = (phase_reg == PH_OUT) ? S_TH_LOAD : S_INT0;
            end
            S_INT0:
                state_next = S_INT1;
            S_INT1:
            begin
                k_next = '0;
                if (phase_reg == PH_FAST)
                begin
                    phase_next = PH_SLOW;
                    state_next = S_MAC;
                end
                else if (d_reg == HID_W'(HIDDEN_UNITS - 1))
                begin
                    phase_next = PH_TF;
                    d_next     = '0;
                    state_next = S_TH_LOAD;
                end
                else
                begin
                    phase_next = PH_FAST;
                    d_next     = d_reg + HID_W'(1);
                    state_next = S_MAC;
                end
            end
            S_TH_LOAD:
                state_next = S_TH_BIT;
            S_TH_BIT:
            begin
                if (bit_reg[4])
                    state_next = S_DIV;
                else if (mag_reg[bit_reg[3:0]])
                    state_next = S_TH_MLO;
            end
            S_TH_MLO:
                state_next = S_TH_MHI;
            S_TH_MHI:
                state_next = S_TH_ACC;
            S_TH_ACC:
                state_next = S_TH_BIT;
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = S_TH_DONE;
            end
            S_TH_DONE:
            begin
                priority if (phase_reg == PH_TF)
                begin
                    phase_next = PH_TS;
                    state_next = S_TH_LOAD;
                end
                else if (phase_reg == PH_TS)
                begin
                    if (d_reg == HID_W'(HIDDEN_UNITS - 1))
                    begin
                        phase_next = PH_OUT;
                        d_next     = '0;
                        k_next     = '0;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        phase_next = PH_TF;
                        d_next     = d_reg + HID_W'(1);
                        state_next = S_TH_LOAD;
                    end
                end
                else if (d_reg == HID_W'(OUTPUT_UNITS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    d_next     = d_reg + HID_W'(1);
                    k_next     = '0;
                    state_next = S_MAC;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // weight memory: written on load beats, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (item_acc && item.kind == KIND_LOAD && load_ok)
            mem[load_addr] <= item.weight_value;
        rdata_reg <= mem[term_addr];
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        a1_reg   <= term_a;
        if (item_acc)
        begin
            x0_reg <= item.x_first;
            x1_reg <= item.x_second;
        end
        if (state_reg == S_MAC && k_reg == '0)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);

        unique case (state_reg)
            S_TH_LOAD:
            begin
                e_reg   <= E_ONE;
                neg_reg <= th_src[15];
                mag_reg <= th_mag[15:0];
            end
            S_TH_BIT:
            begin
                rem_reg <= n_val;
                dsh_reg <= dd_val;
                q_reg   <= '0;
                cnt_reg <= 4'd12;
            end
            S_TH_MHI:
                lo_reg <= prod_reg[E_FRAC+19:20];
            S_TH_ACC:
                e_reg <= E_W'((prod_reg + PROD_W'(lo_reg)) >>> 20);
            S_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[11:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[11:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 4'd1;
            end
            S_TH_DONE:
            begin
                if (phase_reg == PH_OUT && d_reg == '0)
                    y0_reg <= tq;
            end
            default:
            begin
            end
        endcase

        if (state_reg == S_FINISH && (!out_valid_reg || result.ready))
        begin
            y_first_reg  <= y0_reg;
            y_second_reg <= tq;
            sat_reg      <= flag_reg;
        end
    end

    // control and network state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FAST;
            d_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            bit_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            inv_fast_reg  <= INV_FAST_RESET;
            inv_slow_reg  <= INV_SLOW_RESET;
            for (int i = 0; i < HIDDEN_UNITS; i++)
            begin
                fpot_reg[i] <= '0;
                spot_reg[i] <= '0;
                fctx_reg[i] <= '0;
                sctx_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            d_reg     <= d_next;
            k_reg     <= k_next;
            v1_reg    <= (state_reg == S_MAC);
            v2_reg    <= v1_reg;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_INV_FAST: inv_fast_reg <= cfg_data;
                    REG_INV_SLOW: inv_slow_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (item_acc && item.kind == KIND_CLEAR)
            begin
                for (int i = 0; i < HIDDEN_UNITS; i++)
                begin
                    fpot_reg[i] <= '0;
                    spot_reg[i] <= '0;
                    fctx_reg[i] <= '0;
                    sctx_reg[i] <= '0;
                end
            end

            if (item_acc && item.kind == KIND_STEP)
                flag_reg <= 1'b0;

            unique case (state_reg)
                S_INT0:
                begin
                    if (pre_ovf)
                        flag_reg <= 1'b1;
                end
                S_INT1:
                begin
                    if (pot_ovf)
                        flag_reg <= 1'b1;
                    if (phase_reg == PH_SLOW)
                        spot_reg[d_reg] <= pot_new;
                    else
                        fpot_reg[d_reg] <= pot_new;
                end
                S_TH_LOAD:
                begin
                    bit_reg <= '0;
                    if (phase_reg == PH_OUT && pre_ovf)
                        flag_reg <= 1'b1;
                end
                S_TH_BIT:
                begin
                    if (!bit_reg[4] && !mag_reg[bit_reg[3:0]])
                        bit_reg <= bit_reg + 5'd1;
                end
                S_TH_ACC:
                    bit_reg <= bit_reg + 5'd1;
                S_TH_DONE:
                begin
                    if (phase_reg == PH_TF)
                        fctx_reg[d_reg] <= 16'(tq);
                    else if (phase_reg == PH_TS)
                        sctx_reg[d_reg] <= 16'(tq);
                end
                default:
                begin
                end
            endcase

            if (state_reg == S_FINISH && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_mul_free, state_reg == S_INT0 || state_reg == S_TH_MLO, !v1_reg && !v2_reg, "multiplier taken while MAC beats in flight")
    `ASSERT_IMPLY(a_prod_after_read, v2_reg, $past(v1_reg), "product stage without a weight read")
    `ASSERT_IMPLY(a_out_from_finish, $rose(out_valid_reg), $past(state_reg) == S_FINISH, "result raised outside finish")

endmodule

FILE: bench/mtrnn_forward_step_test.sv
module mtrnn_forward_step_test;
    import mtrnn_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         matrix_sel;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] x_first;
        logic signed [15:0] x_second;
    } net_cmd_t;

    typedef struct packed {
        logic signed [13:0] y_first;
        logic signed [13:0] y_second;
        logic               saturated;
    } net_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mtrnn_in_if  in_ch ();
    mtrnn_out_if out_ch ();

    mtrnn_forward_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch.sink),
        .result    (out_ch.source)
    );

    // shadow of the network
    logic signed [15:0] wmem [MEM_DEPTH];
    int                 fast_pot [HIDDEN_UNITS];
    int                 slow_pot [HIDDEN_UNITS];
    int                 fast_ctx [HIDDEN_UNITS];
    int                 slow_ctx [HIDDEN_UNITS];
    int unsigned        tau_fast;
    int unsigned        tau_slow;
    bit                 clamp_seen;

    net_out_t pending_outputs [$];
    int       src_idle;
    int       snk_idle;
    int       errors;
    int       steps_sent;
    int       loads_sent;
    int       results_seen;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 3_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint round_q12(longint v);
        return (v + 2048) >>> 12;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
        begin
            clamp_seen = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            clamp_seen = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint tanh_q12(longint v);
        real r;
        r = 4096.0 * $tanh(real'(v) / 4096.0);
        if (r >= 0.0)
            return longint'($floor(r + 0.5));
        return -longint'($floor(-r + 0.5));
    endfunction

    function automatic int leak_update(int pot, longint acc, int unsigned inv);
        longint pre;
        longint delta;
        pre = clamp16(round_q12(acc));
        delta = round_q12(longint'(inv) * (pre - pot));
        return int'(clamp16(longint'(pot) + delta));
    endfunction

    function automatic longint wv(int addr);
        return longint'(wmem[addr]);
    endfunction

    function automatic void store_weight(net_cmd_t c);
        int src;
        int dst;
        int addr;
        bit hid_ok;
        src = c.row_index;
        dst = c.col_index;
        addr = -1;
        hid_ok = src < HIDDEN_UNITS && dst < HIDDEN_UNITS;
        case (c.matrix_sel)
            SEL_IN_FAST:
                if (src < INPUT_UNITS && dst < HIDDEN_UNITS) addr = OFF_IF + src * HIDDEN_UNITS + dst;
            SEL_FAST_FAST: if (hid_ok) addr = OFF_FF + src * HIDDEN_UNITS + dst;
            SEL_SLOW_FAST: if (hid_ok) addr = OFF_SF + src * HIDDEN_UNITS + dst;
            SEL_SLOW_SLOW: if (hid_ok) addr = OFF_SS + src * HIDDEN_UNITS + dst;
            SEL_FAST_SLOW: if (hid_ok) addr = OFF_FS + src * HIDDEN_UNITS + dst;
            SEL_FAST_OUT:
                if (src < HIDDEN_UNITS && dst < OUTPUT_UNITS) addr = OFF_FO + src * OUTPUT_UNITS + dst;
            SEL_BIAS_FAST: if (dst < HIDDEN_UNITS) addr = OFF_BF + dst;
            SEL_BIAS_SLOW: if (dst < HIDDEN_UNITS) addr = OFF_BS + dst;
            SEL_BIAS_OUT:  if (dst < OUTPUT_UNITS) addr = OFF_BO + dst;
            default: addr = -1;
        endcase
        if (addr >= 0)
            wmem[addr] = c.weight_value;
    endfunction

    function automatic net_out_t network_step(net_cmd_t c);
        int       fprev [HIDDEN_UNITS];
        int       sprev [HIDDEN_UNITS];
        longint   fa;
        longint   sa;
        longint   acc;
        longint   ys [OUTPUT_UNITS];
        net_out_t o;
        clamp_seen = 1'b0;
        fprev = fast_ctx;
        sprev = slow_ctx;
        for (int d = 0; d < HIDDEN_UNITS; d++)
        begin
            fa = wv(OFF_BF + d) * 4096;
            sa = wv(OFF_BS + d) * 4096;
            fa += longint'(c.x_first) * wv(OFF_IF + d);
            fa += longint'(c.x_second) * wv(OFF_IF + HIDDEN_UNITS + d);
            for (int s = 0; s < HIDDEN_UNITS; s++)
            begin
                fa += longint'(fprev[s]) * wv(OFF_FF + s * HIDDEN_UNITS + d);
                fa += longint'(sprev[s]) * wv(OFF_SF + s * HIDDEN_UNITS + d);
                sa += longint'(sprev[s]) * wv(OFF_SS + s * HIDDEN_UNITS + d);
                sa += longint'(fprev[s]) * wv(OFF_FS + s * HIDDEN_UNITS + d);
            end
            fast_pot[d] = leak_update(fast_pot[d], fa, tau_fast);
            slow_pot[d] = leak_update(slow_pot[d], sa, tau_slow);
        end
        for (int d = 0; d < HIDDEN_UNITS; d++)
        begin
            fast_ctx[d] = int'(tanh_q12(fast_pot[d]));
            slow_ctx[d] = int'(tanh_q12(slow_pot[d]));
        end
        for (int d = 0; d < OUTPUT_UNITS; d++)
        begin
            acc = wv(OFF_BO + d) * 4096;
            for (int s = 0; s < HIDDEN_UNITS; s++)
                acc += longint'(fast_ctx[s]) * wv(OFF_FO + s * OUTPUT_UNITS + d);
            ys[d] = tanh_q12(clamp16(round_q12(acc)));
        end
        o.y_first = 14'(ys[0]);
        o.y_second = 14'(ys[1]);
        o.saturated = clamp_seen;
        return o;
    endfunction

    function automatic void clear_state();
        for (int d = 0; d < HIDDEN_UNITS; d++)
        begin
            fast_pot[d] = 0;
            slow_pot[d] = 0;
            fast_ctx[d] = 0;
            slow_ctx[d] = 0;
        end
    endfunction

    // called at a rising edge; returns just after the edge that took the beat
    task automatic send_cmd(net_cmd_t c);
        if ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= c.kind;
        in_ch.matrix_sel <= c.matrix_sel;
        in_ch.row_index <= c.row_index;
        in_ch.col_index <= c.col_index;
        in_ch.weight_value <= c.weight_value;
        in_ch.x_first <= c.x_first;
        in_ch.x_second <= c.x_second;
        do
            @(posedge clk);
        while (!in_ch.ready);
        case (c.kind)
            KIND_LOAD:
            begin
                store_weight(c);
                loads_sent++;
            end
            KIND_STEP:
            begin
                pending_outputs.push_back(network_step(c));
                steps_sent++;
            end
            KIND_CLEAR: clear_state();
            default: ;
        endcase
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_taus(int unsigned f, int unsigned s);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_INV_FAST;
        cfg_data <= CFG_DATA_W'(f);
        @(posedge clk);
        cfg_index <= REG_INV_SLOW;
        cfg_data <= CFG_DATA_W'(s);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        tau_fast = f;
        tau_slow = s;
    endtask

    function automatic net_cmd_t blank_cmd(logic [1:0] k);
        net_cmd_t c;
        c = '0;
        c.kind = k;
        c.x_first = 16'($urandom);
        c.x_second = 16'($urandom);
        c.weight_value = 16'($urandom);
        return c;
    endfunction

    function automatic net_cmd_t load_cmd(logic [3:0] sel, int r, int col, int val);
        net_cmd_t c;
        c = blank_cmd(KIND_LOAD);
        c.matrix_sel = sel;
        c.row_index = 6'(r);
        c.col_index = 6'(col);
        c.weight_value = 16'(val);
        return c;
    endfunction

    function automatic net_cmd_t step_cmd(int a, int b);
        net_cmd_t c;
        c = blank_cmd(KIND_STEP);
        c.x_first = 16'(a);
        c.x_second = 16'(b);
        return c;
    endfunction

    function automatic int modest_weight();
        return int'($urandom_range(2047)) - 1024;
    endfunction

    // an in-range load to a random target
    function automatic net_cmd_t random_load();
        logic [3:0] sel;
        int r;
        int col;
        sel = 4'($urandom_range(8));
        r = $urandom_range(HIDDEN_UNITS - 1);
        col = $urandom_range(HIDDEN_UNITS - 1);
        if (sel == SEL_IN_FAST)
            r = $urandom_range(INPUT_UNITS - 1);
        if (sel == SEL_FAST_OUT || sel == SEL_BIAS_OUT)
            col = $urandom_range(OUTPUT_UNITS - 1);
        if (sel >= SEL_BIAS_FAST)
            r = $urandom_range(63);
        return load_cmd(sel, r, col,
                        ($urandom_range(9) == 0) ? int'($urandom) : modest_weight());
    endfunction

    task automatic test_preload();
        for (int a = 0; a < INPUT_UNITS; a++)
            for (int d = 0; d < HIDDEN_UNITS; d++)
                send_cmd(load_cmd(SEL_IN_FAST, a, d, modest_weight()));
        for (int m = SEL_FAST_FAST; m <= SEL_FAST_SLOW; m++)
            for (int a = 0; a < HIDDEN_UNITS; a++)
                for (int d = 0; d < HIDDEN_UNITS; d++)
                    send_cmd(load_cmd(4'(m), a, d, modest_weight() / 2));
        for (int a = 0; a < HIDDEN_UNITS; a++)
            for (int d = 0; d < OUTPUT_UNITS; d++)
                send_cmd(load_cmd(SEL_FAST_OUT, a, d, modest_weight()));
        for (int d = 0; d < HIDDEN_UNITS; d++)
        begin
            send_cmd(load_cmd(SEL_BIAS_FAST, $urandom_range(63), d, modest_weight()));
            send_cmd(load_cmd(SEL_BIAS_SLOW, $urandom_range(63), d, modest_weight()));
        end
        for (int d = 0; d < OUTPUT_UNITS; d++)
            send_cmd(load_cmd(SEL_BIAS_OUT, 0, d, modest_weight()));
    endtask

    task automatic test_corners();
        send_cmd(step_cmd(0, 0));
        send_cmd(step_cmd(32767, -32768));
        send_cmd(step_cmd(-32768, 32767));
        // huge biases and input weights push sums into clamping
        send_cmd(load_cmd(SEL_BIAS_FAST, 63, 0, 32767));
        send_cmd(load_cmd(SEL_BIAS_SLOW, 0, 15, -32768));
        send_cmd(load_cmd(SEL_IN_FAST, 1, 15, -32768));
        send_cmd(load_cmd(SEL_FAST_OUT, 15, 1, 32767));
        send_cmd(load_cmd(SEL_BIAS_OUT, 0, 1, -32768));
        send_cmd(step_cmd(32767, 32767));
        send_cmd(step_cmd(-32768, -32768));
        send_cmd(blank_cmd(KIND_CLEAR));
        send_cmd(blank_cmd(2'd3));
        // out-of-range loads must leave the memory alone
        send_cmd(load_cmd(4'd9, 0, 0, 32767));
        send_cmd(load_cmd(4'd15, 63, 63, -1));
        send_cmd(load_cmd(SEL_IN_FAST, 2, 0, 12345));
        send_cmd(load_cmd(SEL_FAST_OUT, 0, 2, 12345));
        send_cmd(load_cmd(SEL_FAST_FAST, 16, 0, 12345));
        send_cmd(load_cmd(SEL_SLOW_SLOW, 0, 63, 12345));
        send_cmd(load_cmd(SEL_BIAS_OUT, 5, 2, 12345));
        send_cmd(load_cmd(SEL_BIAS_FAST, 0, 16, 12345));
        send_cmd(step_cmd(4096, -4096));
        send_cmd(load_cmd(SEL_BIAS_FAST, 0, 0, 100));
        send_cmd(load_cmd(SEL_BIAS_SLOW, 0, 15, -100));
        send_cmd(load_cmd(SEL_IN_FAST, 1, 15, 300));
        send_cmd(step_cmd(1, -1));
        drain_results();
    endtask

    task automatic test_random_traffic(int count);
        net_cmd_t c;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                c = random_load();
            else if (pick < 66)
            begin
                c = blank_cmd(KIND_LOAD);
                c.matrix_sel = 4'($urandom);
                c.row_index = 6'($urandom);
                c.col_index = 6'($urandom);
            end
            else if (pick < 94)
            begin
                c = blank_cmd(KIND_STEP);
                if ($urandom_range(3) != 0)
                begin
                    c.x_first = 16'(int'($urandom_range(16383)) - 8192);
                    c.x_second = 16'(int'($urandom_range(16383)) - 8192);
                end
            end
            else if (pick < 97)
                c = blank_cmd(KIND_CLEAR);
            else
                c = blank_cmd(2'd3);
            send_cmd(c);
            if (n == count / 2)
                drain_results();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle);
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (pending_outputs.size() == 0)
                begin
                    $error("result beat with no step pending");
                    errors++;
                end
                else
                begin
                    net_out_t e;
                    e = pending_outputs.pop_front();
                    if (out_ch.y_first !== e.y_first)
                    begin
                        $error("y_first expected %0d got %0d", e.y_first, out_ch.y_first);
                        errors++;
                    end
                    if (out_ch.y_second !== e.y_second)
                    begin
                        $error("y_second expected %0d got %0d", e.y_second, out_ch.y_second);
                        errors++;
                    end
                    if (out_ch.saturated !== e.saturated)
                    begin
                        $error("saturated expected %0d got %0d", e.saturated,
                               out_ch.saturated);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_LOAD;
        in_ch.matrix_sel = '0;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.weight_value = '0;
        in_ch.x_first = '0;
        in_ch.x_second = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        steps_sent = 0;
        loads_sent = 0;
        results_seen = 0;
        for (int a = 0; a < MEM_DEPTH; a++)
            wmem[a] = '0;
        clear_state();
        tau_fast = INV_FAST_RESET;
        tau_slow = INV_SLOW_RESET;
        src_idle = 0;
        snk_idle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle = 20;
        snk_idle = 30;
        test_preload();
        test_corners();

        src_idle = 32;
        snk_idle = 85;
        write_taus(4096, 8191);
        test_random_traffic(175);

        src_idle = 85;
        snk_idle = 32;
        write_taus(0, 0);
        test_random_traffic(170);

        src_idle = 0;
        snk_idle = 0;
        write_taus(1365, 410);
        test_random_traffic(175);

        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d weight loads and %0d network steps, %0d results checked",
                 loads_sent, steps_sent, results_seen);
        $display("tau settings: reset, full/over-range, zero, and mid values");
        if (errors == 0 && pending_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
